// ----- rtl/core/sptb_pkg.sv -----
`timescale 1ns / 1ps

package sptb_pkg;

	localparam int DATA_W      = 32;
	localparam int SEC_W       = 23;
	localparam int MAX_GAP_DEF = 10;

	// ms / 1000 == (ms * RECIP_1000) >> RECIP_SHIFT, exact over 32 bits
	localparam int RECIP_W     = 29;
	localparam int RECIP_SHIFT = 38;
	localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;

	localparam int DIV_STEPS = DATA_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

endpackage

// ----- rtl/core/seconds_to_packet_index_builder_top.sv -----
`timescale 1ns / 1ps

// channel  handshake                 payload
// item     item_valid / item_ready   operation, packet_valid, packet_time_ms
// entry    entry_valid / entry_ready entry_second, entry_packet, seconds_total,
//                                    final_entry, last
//
// Packet indexing nothing, or end of stream: IDLE, EVAL. Packet with one entry: IDLE, EVAL, EMIT.
// Packet skipping seconds: IDLE, EVAL, DIV, EMIT; the shared compare-subtract unit
// runs a 32-step division of the packet span by the gap, then one step per filled second while the output is free.
// Seconds come from a reciprocal multiply of the timestamp on acceptance.
// Reset (arst_n low) returns to the start of a stream; no clearing pass.
// A full output register holds the sequencer; item_ready is high only when idle.

module seconds_to_packet_index_builder_top
	import sptb_pkg::*;
#(
	parameter int MAX_GAP = MAX_GAP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic              operation,
	input  logic              packet_valid,
	input  logic [DATA_W-1:0] packet_time_ms,
	output logic              entry_valid,
	input  logic              entry_ready,
	output logic [SEC_W-1:0]  entry_second,
	output logic [DATA_W-1:0] entry_packet,
	output logic [SEC_W-1:0]  seconds_total,
	output logic              final_entry,
	output logic              last
);

	localparam int GW = $clog2(MAX_GAP + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t              state_q;
	logic [DATA_W-1:0]   counter_q;
	logic [DATA_W-1:0]   cur_sec_q;
	logic [DATA_W-1:0]   cur_entry_q;

	logic                op_q;
	logic                pv_q;
	logic [SEC_W-1:0]    sec_q;
	logic [DATA_W-1:0]   pkt_q;
	logic [DATA_W-1:0]   k_q;
	logic [DATA_W-1:0]   val_q;
	logic [DATA_W-1:0]   dvd_q;
	logic [GW-1:0]       rem_q;
	logic [GW-1:0]       r_q;
	logic [GW-1:0]       gap_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [DATA_W+RECIP_W-1:0] prod;
	logic [DATA_W-1:0]   sec_ext;
	logic [DATA_W-1:0]   limit;
	logic [DATA_W-1:0]   nxt;
	logic [DATA_W-1:0]   gap_full;
	logic [DATA_W-1:0]   val_new;
	logic                take;
	logic                need_fill;
	logic                done;
	logic                slot_free;

	logic [GW:0]         cs_a;
	logic                cs_ge;
	logic [GW-1:0]       cs_diff;

	logic                ld;
	logic [SEC_W-1:0]    o_sec;
	logic [DATA_W-1:0]   o_pkt;
	logic [SEC_W-1:0]    o_tot;
	logic                o_fin;
	logic                o_last;

	assign item_ready = (state_q == ST_IDLE);
	assign slot_free  = !entry_valid || entry_ready;

	assign prod      = {{(DATA_W+RECIP_W-DATA_W){1'b0}}, packet_time_ms}
	                 * {{(DATA_W+RECIP_W-RECIP_W){1'b0}}, RECIP_1000};
	assign sec_ext   = {{(DATA_W-SEC_W){1'b0}}, sec_q};
	assign limit     = cur_sec_q + DATA_W'(MAX_GAP);
	assign nxt       = cur_sec_q + DATA_W'(1);
	assign gap_full  = sec_ext - cur_sec_q;
	assign take      = pv_q && (sec_ext != cur_sec_q) && (sec_ext <= limit);
	assign need_fill = sec_ext > nxt;
	assign done      = (k_q == sec_ext);
	assign val_new   = val_q + dvd_q + DATA_W'(cs_ge);

	// shared unit: division step, or remainder update while filling
	assign cs_a = (state_q == ST_DIV) ? {rem_q, dvd_q[DATA_W-1]}
	                                  : ({1'b0, r_q} + {1'b0, rem_q});

	sptb_csub #(.W(GW)) u_csub (
		.a    (cs_a),
		.b    (gap_q),
		.ge   (cs_ge),
		.diff (cs_diff)
	);

	always_comb begin
		ld     = 1'b0;
		o_sec  = k_q[SEC_W-1:0];
		o_pkt  = val_new;
		o_tot  = '0;
		o_fin  = 1'b0;
		o_last = 1'b0;
		case (state_q)
			ST_EVAL: begin
				if (op_q && slot_free) begin
					ld     = 1'b1;
					o_sec  = nxt[SEC_W-1:0];
					o_pkt  = counter_q - DATA_W'(1);
					o_tot  = nxt[SEC_W-1:0];
					o_fin  = 1'b1;
					o_last = 1'b1;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					ld = 1'b1;
					if (done) begin
						o_sec  = sec_q;
						o_pkt  = pkt_q;
						o_last = 1'b1;
					end
				end
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			counter_q   <= '0;
			cur_sec_q   <= '1;
			cur_entry_q <= '0;
			entry_valid <= 1'b0;
		end else begin
			if (ld)
				entry_valid <= 1'b1;
			else if (entry_ready)
				entry_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_EVAL;
						if (!operation)
							counter_q <= counter_q + DATA_W'(1);
					end
				end
				ST_EVAL: begin
					if (op_q) begin
						if (slot_free) begin
							state_q     <= ST_IDLE;
							counter_q   <= '0;
							cur_sec_q   <= '1;
							cur_entry_q <= '0;
						end
					end else if (take) begin
						state_q <= need_fill ? ST_DIV : ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free && done) begin
						state_q     <= ST_IDLE;
						cur_sec_q   <= sec_ext;
						cur_entry_q <= pkt_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					op_q  <= operation;
					pv_q  <= packet_valid;
					sec_q <= prod[RECIP_SHIFT +: SEC_W];
					pkt_q <= counter_q;
				end
			end
			ST_EVAL: begin
				// no fill (including a second earlier than the last): go straight to it
				k_q   <= need_fill ? nxt : sec_ext;
				val_q <= cur_entry_q;
				r_q   <= '0;
				dvd_q <= pkt_q - cur_entry_q;
				rem_q <= '0;
				cnt_q <= '0;
				gap_q <= gap_full[GW-1:0];
			end
			ST_DIV: begin
				dvd_q <= {dvd_q[DATA_W-2:0], cs_ge};
				rem_q <= cs_diff;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_EMIT: begin
				if (slot_free && !done) begin
					k_q   <= k_q + DATA_W'(1);
					val_q <= val_new;
					r_q   <= cs_diff;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
		if (ld) begin
			entry_second  <= o_sec;
			entry_packet  <= o_pkt;
			seconds_total <= o_tot;
			final_entry   <= o_fin;
			last          <= o_last;
		end
	end

`ifndef SYNTHESIS
	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid && final_entry |-> last)
		else $error("closing entry without last");

	a_fill_clean: assert property (@(posedge clk) disable iff (!arst_n)
		entry_valid && !last |-> !final_entry && (seconds_total == '0))
		else $error("fill entry carries closing fields");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < gap_q)
		else $error("division remainder out of range");

	a_stream_reset: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EVAL && op_q && slot_free |=>
		(counter_q == '0) && (cur_sec_q == '1) && (cur_entry_q == '0))
		else $error("state not cleared after end of stream");
`endif

endmodule

// ----- rtl/core/sptb_csub.sv -----
`timescale 1ns / 1ps

module sptb_csub #(
	parameter int W = 4
) (
	input  logic [W:0]   a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	logic [W:0] sub;

	assign sub  = a - {1'b0, b};
	assign ge   = a >= {1'b0, b};
	assign diff = ge ? sub[W-1:0] : a[W-1:0];

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

import sptb_pkg::*;

typedef enum logic {
	OP_PACKET = 1'b0,
	OP_END    = 1'b1
} item_op_e;

typedef struct packed {
	logic [SEC_W-1:0]  second;
	logic [DATA_W-1:0] packet;
	logic [SEC_W-1:0]  total;
	logic              fin;
	logic              lst;
} index_entry_t;

class seek_index_board;
	logic [DATA_W-1:0] cur_sec;
	logic [DATA_W-1:0] cur_entry;
	logic [DATA_W-1:0] pkt_cnt;
	index_entry_t      pending[$];
	int                failures;
	int                requests;
	int                entries;
	int                fills;
	int                closings;

	function new();
		failures  = 0;
		requests  = 0;
		entries   = 0;
		fills     = 0;
		closings  = 0;
		clear_stream();
	endfunction

	function void clear_stream();
		cur_sec   = '1;
		cur_entry = '0;
		pkt_cnt   = '0;
	endfunction

	function void note_request(logic op, logic vld, logic [DATA_W-1:0] ms);
		logic [DATA_W-1:0] pkt;
		logic [DATA_W-1:0] sec;
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] lim;
		logic [DATA_W-1:0] gap;
		logic [DATA_W-1:0] span;
		logic [DATA_W-1:0] k;
		logic [63:0]       prod;
		logic [63:0]       quot;
		index_entry_t      e;
		requests++;
		if (op == OP_END) begin
			sec = cur_sec + 1;
			e.second = sec[SEC_W-1:0];
			e.packet = pkt_cnt - 1;
			e.total  = sec[SEC_W-1:0];
			e.fin    = 1'b1;
			e.lst    = 1'b1;
			pending.push_back(e);
			clear_stream();
			return;
		end
		pkt = pkt_cnt;
		pkt_cnt = pkt_cnt + 1;
		if (!vld)
			return;
		sec  = ms / 1000;
		prev = cur_sec;
		lim  = prev + MAX_GAP_DEF;
		if (sec == prev || sec > lim)
			return;
		// skipped seconds, interpolated from the previous entry
		if (sec > prev + 1) begin
			gap  = sec - prev;
			span = pkt - cur_entry;
			for (k = prev + 1; k < sec; k++) begin
				prod = {32'd0, k - prev} * {32'd0, span};
				quot = prod / {32'd0, gap};
				e.second = k[SEC_W-1:0];
				e.packet = cur_entry + quot[DATA_W-1:0];
				e.total  = '0;
				e.fin    = 1'b0;
				e.lst    = 1'b0;
				pending.push_back(e);
			end
		end
		e.second = sec[SEC_W-1:0];
		e.packet = pkt;
		e.total  = '0;
		e.fin    = 1'b0;
		e.lst    = 1'b1;
		pending.push_back(e);
		cur_sec   = sec;
		cur_entry = pkt;
	endfunction

	function void field_check(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	function void check_entry(index_entry_t got);
		index_entry_t want;
		if (pending.size() == 0) begin
			failures++;
			$display("%0t: unexpected entry, expected none, actual second %0d packet %0h",
				$time, got.second, got.packet);
			return;
		end
		want = pending.pop_front();
		entries++;
		if (want.fin)
			closings++;
		else if (!want.lst)
			fills++;
		field_check("entry_second", want.second, got.second);
		field_check("entry_packet", want.packet, got.packet);
		field_check("seconds_total", want.total, got.total);
		field_check("final_entry", want.fin, got.fin);
		field_check("last", want.lst, got.lst);
	endfunction
endclass

module tb_top;

	localparam int RANDOM_ITEMS = 460;
	localparam int CALM_FROM    = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 60;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	logic              operation;
	logic              packet_valid;
	logic [DATA_W-1:0] packet_time_ms;
	logic              entry_valid;
	logic              entry_ready;
	logic [SEC_W-1:0]  entry_second;
	logic [DATA_W-1:0] entry_packet;
	logic [SEC_W-1:0]  seconds_total;
	logic              final_entry;
	logic              last;

	seek_index_board board;
	bit              calm;
	int              idle_cycles;
	int              stall_left;

	seconds_to_packet_index_builder_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.operation      (operation),
		.packet_valid   (packet_valid),
		.packet_time_ms (packet_time_ms),
		.entry_valid    (entry_valid),
		.entry_ready    (entry_ready),
		.entry_second   (entry_second),
		.entry_packet   (entry_packet),
		.seconds_total  (seconds_total),
		.final_entry    (final_entry),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int pick_gap();
		if (calm || $urandom_range(0, 4) != 0)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	task automatic send_request(input item_op_e op, input logic vld, input logic [DATA_W-1:0] ms);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid     <= 1'b1;
		operation      <= op;
		packet_valid   <= vld;
		packet_time_ms <= ms;
		do @(posedge clk); while (!item_ready);
		board.note_request(op, vld, ms);
	endtask

	task automatic send_random();
		int                pick;
		int                back;
		logic [DATA_W-1:0] sec;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			send_request(OP_END, 1'($urandom), $urandom);
		end else if (pick < 10) begin
			send_request(OP_PACKET, 1'b0, $urandom);
		end else if (pick < 14) begin
			send_request(OP_PACKET, 1'b1, $urandom);
		end else if (pick < 19 && board.cur_sec != '1 && board.cur_sec != 0) begin
			back = $urandom_range(1, (board.cur_sec < 5) ? board.cur_sec : 5);
			sec = board.cur_sec - back;
			send_request(OP_PACKET, 1'b1, sec * 1000 + $urandom_range(0, 999));
		end else begin
			if ($urandom_range(0, 9) < 4)
				sec = board.cur_sec;
			else
				sec = board.cur_sec + $urandom_range(1, 11);
			if (sec > 32'd4294966)
				send_request(OP_PACKET, 1'b1, $urandom);
			else
				send_request(OP_PACKET, 1'b1, sec * 1000 + $urandom_range(0, 999));
		end
	endtask

	// entry side: ready drops in short bursts
	initial begin
		entry_ready = 1'b0;
		stall_left  = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				entry_ready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				entry_ready <= 1'b0;
				stall_left = $urandom_range(0, 2);
			end else begin
				entry_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (entry_valid && entry_ready)
			board.check_entry({entry_second, entry_packet, seconds_total, final_entry, last});
		if ((entry_valid && entry_ready) || (item_valid && item_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("seconds_to_packet_index_builder_top test failed");
			$finish;
		end
	end

	initial begin
		board          = new();
		calm           = 1'b0;
		idle_cycles    = 0;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		operation      = OP_PACKET;
		packet_valid   = 1'b0;
		packet_time_ms = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		send_request(OP_END, 1'b0, 32'd0);
		send_request(OP_PACKET, 1'b0, 32'd0);
		send_request(OP_PACKET, 1'b1, 32'd10000);
		send_request(OP_PACKET, 1'b1, 32'd9999);
		send_request(OP_PACKET, 1'b1, 32'd9500);
		send_request(OP_PACKET, 1'b1, 32'd20999);
		send_request(OP_PACKET, 1'b1, 32'd19000);
		send_request(OP_PACKET, 1'b1, 32'd20000);
		send_request(OP_PACKET, 1'b1, 32'd5123);
		send_request(OP_PACKET, 1'b0, 32'hFFFF_FFFF);
		send_request(OP_PACKET, 1'b1, 32'hFFFF_FFFF);
		send_request(OP_PACKET, 1'b1, 32'd7000);
		send_request(OP_END, 1'b1, 32'hFFFF_FFFF);
		send_request(OP_PACKET, 1'b1, 32'd0);
		send_request(OP_END, 1'b0, 32'hAAAA_AAAA);
		send_request(OP_PACKET, 1'b0, 32'd123);
		send_request(OP_PACKET, 1'b0, 32'h5555_5555);
		send_request(OP_END, 1'b0, 32'd0);
		send_request(OP_PACKET, 1'b0, 32'd0);
		send_request(OP_PACKET, 1'b1, 32'd999);
		send_request(OP_PACKET, 1'b1, 32'd1000);
		send_request(OP_PACKET, 1'b1, 32'd10999);
		send_request(OP_END, 1'b0, 32'd0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= CALM_FROM);
			send_random();
		end
		@(negedge clk);
		item_valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests and %0d index entries,", board.requests, board.entries);
		$display("of which %0d interpolated and %0d closing.", board.fills, board.closings);
		if (board.failures == 0 && board.pending.size() == 0) begin
			$display("seconds_to_packet_index_builder_top test passed");
		end else begin
			$display("seconds_to_packet_index_builder_top test failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/sptb_pkg.sv
rtl/core/sptb_csub.sv
rtl/core/seconds_to_packet_index_builder_top.sv
bench/tb_top.sv
